// File: design/bfic_pkg.sv
// ----------------------------------------------------------------------------
// bfic_pkg
// Shared constants, codes and control types of the interpreter core.
// ----------------------------------------------------------------------------
package bfic_pkg;

    localparam int TAPE_CELLS  = 32768;
    localparam int PROG_LEN    = 4096;
    localparam int STACK_DEPTH = 256;

    localparam int TAPE_AW  = $clog2(TAPE_CELLS);
    localparam int PROG_AW  = $clog2(PROG_LEN);
    localparam int LOAD_W   = $clog2(PROG_LEN + 1);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);

    // Item kinds.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Stored op codes.
    localparam logic [2:0] OP_INC   = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_LEFT  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WAIT       = 3'd1;
    localparam logic [2:0] ST_HALTED     = 3'd2;
    localparam logic [2:0] ST_BRACKET    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_NOT_LOADED = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic link;
        logic clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_link;
        logic clear_last;
    } t_dp_stat;

endpackage

// File: design/brainfuck_interpreter_core.sv
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core
// Loads a program one source byte at a time, then executes it one op per step.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole tape to zero, one cell per clock, so
// busy stays high, and no item is accepted, until all TAPE_CELLS (32768) cells
// are clear. An item is accepted when start is high and busy is low. Each item
// produces exactly one result beat, shown for a single cycle with o_done high;
// the receiver cannot stall it, so capture it on that cycle. An item is captured
// with registered reads of the program, jump and tape memories, then executed
// and written back. Loading a closing bracket adds a link state, because the
// jump memory has one write port and both partners of the bracket pair must be
// recorded. The next item may be presented on the cycle the result beat is
// shown. A step that meets an input op with i_in_valid low reports "waiting
// for input" and repeats that op on the next step.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core import bfic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cmd,
    input  logic [7:0] i_src_byte,
    input  logic       i_src_last,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_valid,
    output logic       o_done,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_in_taken
);

    // Command and status bundles between the sequencer and the datapath.
    t_dp_cmd  ctl;
    t_dp_stat stat;

    // The sequencer owns the handshake and the result strobe.
    bfic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The datapath holds every memory and all architectural state.
    bfic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cmd       (i_cmd),
        .i_src_byte  (i_src_byte),
        .i_src_last  (i_src_last),
        .i_in_byte   (i_in_byte),
        .i_in_valid  (i_in_valid),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_in_taken  (o_in_taken)
    );

endmodule

// File: design/bfic_ram.sv
// ----------------------------------------------------------------------------
// bfic_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bfic_ctrl.sv
// ----------------------------------------------------------------------------
// bfic_ctrl
// Sequencer: tape clearing pass, item accept, execute and bracket link cycles.
// ----------------------------------------------------------------------------
module bfic_ctrl import bfic_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy,
    output logic     o_done
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.need_link ? S_LINK : S_IDLE;
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        n_done = ((r_state == S_EXEC) && !i_stat.need_link) || (r_state == S_LINK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_ctl.capture = accept;
    assign o_ctl.exec    = (r_state == S_EXEC);
    assign o_ctl.link    = (r_state == S_LINK);
    assign o_ctl.clear   = (r_state == S_CLEAR);
    assign o_busy        = (r_state != S_IDLE) || !i_rst_n;
    assign o_done        = r_done;

    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    a_link_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (r_done && r_state == S_IDLE))
        else $error("link cycle did not complete the item");

endmodule

// File: design/bfic_dp.sv
// ----------------------------------------------------------------------------
// bfic_dp
// Datapath: program, jump, bracket stack and tape memories plus machine state.
// ----------------------------------------------------------------------------
module bfic_dp import bfic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_ctl,
    output t_dp_stat   o_stat,
    input  logic       i_cmd,
    input  logic [7:0] i_src_byte,
    input  logic       i_src_last,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_valid,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_in_taken
);

    typedef enum logic [2:0] {
        PH_LOADING,
        PH_RUNNING,
        PH_HALTED,
        PH_BRACKET_ERR,
        PH_TOO_LONG
    } t_phase;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    // Returns {is_command, op}.
    function automatic logic [3:0] decode_char(input logic [7:0] c);
        case (c)
            CH_PLUS:  decode_char = {1'b1, OP_INC};
            CH_MINUS: decode_char = {1'b1, OP_DEC};
            CH_LT:    decode_char = {1'b1, OP_LEFT};
            CH_GT:    decode_char = {1'b1, OP_RIGHT};
            CH_DOT:   decode_char = {1'b1, OP_OUT};
            CH_COMMA: decode_char = {1'b1, OP_IN};
            CH_LBRK:  decode_char = {1'b1, OP_OPEN};
            CH_RBRK:  decode_char = {1'b1, OP_CLOSE};
            default:  decode_char = {1'b0, OP_INC};
        endcase
    endfunction

    function automatic logic [2:0] phase_status(input t_phase ph);
        case (ph)
            PH_LOADING:     phase_status = ST_NOT_LOADED;
            PH_HALTED:      phase_status = ST_HALTED;
            PH_BRACKET_ERR: phase_status = ST_BRACKET;
            PH_TOO_LONG:    phase_status = ST_TOO_LONG;
            default:        phase_status = ST_OK;
        endcase
    endfunction

    // Machine state.
    t_phase              r_phase,      n_phase;
    logic [LOAD_W-1:0]   r_load_count, n_load_count;
    logic [DEPTH_W-1:0]  r_depth,      n_depth;
    logic [LOAD_W-1:0]   r_step,       n_step;
    logic [TAPE_AW-1:0]  r_cp,         n_cp;
    logic [TAPE_AW-1:0]  r_clr_addr;

    // Captured item.
    logic       r_cmd;
    logic [7:0] r_src_byte;
    logic       r_src_last;
    logic [7:0] r_in_byte;
    logic       r_in_valid;

    // Result and pending link write.
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte,  n_out_byte;
    logic [2:0]        r_status,    n_status;
    logic              r_in_taken,  n_in_taken;
    logic [PROG_AW-1:0] r_link_addr;
    logic [PROG_AW-1:0] r_link_data;

    // Memory ports.
    logic [2:0]          op_rdata;
    logic [PROG_AW-1:0]  jump_rdata;
    logic [PROG_AW-1:0]  stack_rdata;
    logic [7:0]          tape_rdata;
    logic                op_we, jump_we, stack_we, tape_we;
    logic [PROG_AW-1:0]  jump_waddr, jump_wdata;
    logic [TAPE_AW-1:0]  tape_waddr;
    logic [7:0]          tape_wdata;
    logic [7:0]          exec_tape_wdata;
    logic                exec_op_we, exec_jump_we, exec_stack_we, exec_tape_we;
    logic [DEPTH_W-1:0]  depth_m1;
    logic [3:0]          dec;
    logic                link_go;

    assign dec      = decode_char(r_src_byte);
    assign depth_m1 = r_depth - DEPTH_W'(1);

    always_comb begin
        logic               err;
        logic               advance;
        logic [PROG_AW-1:0] pc;
        logic [7:0]         cell_val;

        err             = 1'b0;
        advance         = 1'b1;
        pc              = r_step[PROG_AW-1:0];
        cell_val        = tape_rdata;
        n_phase         = r_phase;
        n_load_count    = r_load_count;
        n_depth         = r_depth;
        n_step          = r_step;
        n_cp            = r_cp;
        n_out_valid     = 1'b0;
        n_out_byte      = 8'd0;
        n_status        = ST_OK;
        n_in_taken      = 1'b0;
        exec_op_we      = 1'b0;
        exec_jump_we    = 1'b0;
        exec_stack_we   = 1'b0;
        exec_tape_we    = 1'b0;
        exec_tape_wdata = cell_val;
        link_go         = 1'b0;

        if (r_cmd == CMD_LOAD) begin
            if (r_phase != PH_LOADING) begin
                n_status = (r_phase == PH_RUNNING) ? ST_OK : phase_status(r_phase);
            end else begin
                if (dec[3]) begin
                    if (r_load_count >= LOAD_W'(PROG_LEN)) begin
                        n_phase  = PH_TOO_LONG;
                        n_status = ST_TOO_LONG;
                        err      = 1'b1;
                    end else if (dec[2:0] == OP_OPEN) begin
                        if (r_depth >= DEPTH_W'(STACK_DEPTH)) begin
                            n_phase  = PH_BRACKET_ERR;
                            n_status = ST_BRACKET;
                            err      = 1'b1;
                        end else begin
                            exec_stack_we = 1'b1;
                            n_depth       = r_depth + DEPTH_W'(1);
                        end
                    end else if (dec[2:0] == OP_CLOSE) begin
                        if (r_depth == '0) begin
                            n_phase  = PH_BRACKET_ERR;
                            n_status = ST_BRACKET;
                            err      = 1'b1;
                        end else begin
                            n_depth      = depth_m1;
                            exec_jump_we = 1'b1;
                            link_go      = 1'b1;
                        end
                    end
                    if (!err) begin
                        exec_op_we   = 1'b1;
                        n_load_count = r_load_count + LOAD_W'(1);
                    end
                end
                if (!err && r_src_last) begin
                    if (n_depth != '0) begin
                        n_phase  = PH_BRACKET_ERR;
                        n_status = ST_BRACKET;
                    end else begin
                        n_phase = PH_RUNNING;
                        n_step  = '0;
                    end
                end
            end
        end else if (r_phase != PH_RUNNING) begin
            n_status = phase_status(r_phase);
        end else if (r_step >= r_load_count || r_step >= LOAD_W'(PROG_LEN)) begin
            n_phase  = PH_HALTED;
            n_status = ST_HALTED;
        end else begin
            case (op_rdata)
                OP_INC: begin
                    exec_tape_we    = 1'b1;
                    exec_tape_wdata = cell_val + 8'd1;
                end
                OP_DEC: begin
                    exec_tape_we    = 1'b1;
                    exec_tape_wdata = cell_val - 8'd1;
                end
                OP_LEFT: begin
                    n_cp = (r_cp == '0) ? TAPE_AW'(TAPE_CELLS - 1) : r_cp - TAPE_AW'(1);
                end
                OP_RIGHT: begin
                    n_cp = (r_cp == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : r_cp + TAPE_AW'(1);
                end
                OP_OUT: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cell_val;
                end
                OP_IN: begin
                    if (r_in_valid) begin
                        exec_tape_we    = 1'b1;
                        exec_tape_wdata = r_in_byte;
                        n_in_taken      = 1'b1;
                    end else begin
                        n_status = ST_WAIT;
                        advance  = 1'b0;
                    end
                end
                OP_OPEN: begin
                    if (cell_val == 8'd0) begin
                        pc = jump_rdata;
                    end
                end
                default: begin
                    if (cell_val != 8'd0) begin
                        pc = jump_rdata;
                    end
                end
            endcase
            if (advance) begin
                n_step = LOAD_W'(pc) + LOAD_W'(1);
            end
        end
    end

    // Write port muxing.
    always_comb begin
        op_we    = i_ctl.exec && exec_op_we;
        stack_we = i_ctl.exec && exec_stack_we;
        if (i_ctl.link) begin
            jump_we    = 1'b1;
            jump_waddr = r_link_addr;
            jump_wdata = r_link_data;
        end else begin
            jump_we    = i_ctl.exec && exec_jump_we;
            jump_waddr = r_load_count[PROG_AW-1:0];
            jump_wdata = stack_rdata;
        end
        if (i_ctl.clear) begin
            tape_we    = 1'b1;
            tape_waddr = r_clr_addr;
            tape_wdata = 8'd0;
        end else begin
            tape_we    = i_ctl.exec && exec_tape_we;
            tape_waddr = r_cp;
            tape_wdata = exec_tape_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOADING;
            r_load_count <= '0;
            r_depth      <= '0;
            r_step       <= '0;
            r_cp         <= '0;
            r_clr_addr   <= '0;
        end else begin
            if (i_ctl.exec) begin
                r_phase      <= n_phase;
                r_load_count <= n_load_count;
                r_depth      <= n_depth;
                r_step       <= n_step;
                r_cp         <= n_cp;
            end
            if (i_ctl.clear) begin
                r_clr_addr <= r_clr_addr + TAPE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd      <= i_cmd;
            r_src_byte <= i_src_byte;
            r_src_last <= i_src_last;
            r_in_byte  <= i_in_byte;
            r_in_valid <= i_in_valid;
        end
        if (i_ctl.exec) begin
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_status    <= n_status;
            r_in_taken  <= n_in_taken;
            r_link_addr <= stack_rdata;
            r_link_data <= r_load_count[PROG_AW-1:0];
        end
    end

    bfic_ram #(.WIDTH(3), .DEPTH(PROG_LEN)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (r_load_count[PROG_AW-1:0]),
        .i_wdata (dec[2:0]),
        .i_raddr (r_step[PROG_AW-1:0]),
        .o_rdata (op_rdata)
    );

    bfic_ram #(.WIDTH(PROG_AW), .DEPTH(PROG_LEN)) u_jump_ram (
        .i_clk   (i_clk),
        .i_we    (jump_we),
        .i_waddr (jump_waddr),
        .i_wdata (jump_wdata),
        .i_raddr (r_step[PROG_AW-1:0]),
        .o_rdata (jump_rdata)
    );

    bfic_ram #(.WIDTH(PROG_AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_depth[STACK_AW-1:0]),
        .i_wdata (r_load_count[PROG_AW-1:0]),
        .i_raddr (depth_m1[STACK_AW-1:0]),
        .o_rdata (stack_rdata)
    );

    bfic_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_cp),
        .o_rdata (tape_rdata)
    );

    assign o_stat.need_link  = link_go;
    assign o_stat.clear_last = (r_clr_addr == TAPE_AW'(TAPE_CELLS - 1));
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_status;
    assign o_in_taken  = r_in_taken;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("bracket stack depth out of range");

    a_run_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RUNNING) |-> (r_depth == '0))
        else $error("running with open brackets");

    a_cp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp <= TAPE_AW'(TAPE_CELLS - 1))
        else $error("cell pointer beyond tape");

endmodule
